// File: hw/rtl/wwh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwh_pkg: shared types and constants of the weighted window Hessian
// Holds the per-sample coefficient tables, the sequencer states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package wwh_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned WEIGHT_BITS     = 16;
  localparam int unsigned COEF_BITS       = 16;
  localparam int unsigned WIN_SIZE        = 25;
  localparam int unsigned CNT_BITS        = 5;
  localparam int unsigned DXX_BITS        = 27;
  localparam int unsigned DXY_BITS        = 25;
  localparam int          DXX_LIM         = 33554432;
  localparam int          DXY_LIM         = 8388608;
  // Headroom of the accumulators above the sample width.
  localparam int unsigned ACC_EXTRA       = 19;

  localparam logic [CNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(WIN_SIZE);

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // The weighted 3x3 sums are linear in the samples, so each window position
  // carries one folded coefficient per Hessian entry (row-major order).
  localparam coef_t KXX [WIN_SIZE] = '{
    16'sd0,     16'sd0,     16'sd0,      16'sd0,     16'sd0,
    16'sd2943,  16'sd2116,  -16'sd10118, 16'sd2116,  16'sd2943,
    16'sd8002,  16'sd5747,  -16'sd27498, 16'sd5747,  16'sd8002,
    16'sd2943,  16'sd2116,  -16'sd10118, 16'sd2116,  16'sd2943,
    16'sd0,     16'sd0,     16'sd0,      16'sd0,     16'sd0
  };

  localparam coef_t KYY [WIN_SIZE] = '{
    16'sd0,     16'sd2943,   16'sd8002,   16'sd2943,   16'sd0,
    16'sd0,     16'sd2116,   16'sd5747,   16'sd2116,   16'sd0,
    16'sd0,     -16'sd10118, -16'sd27498, -16'sd10118, 16'sd0,
    16'sd0,     16'sd2116,   16'sd5747,   16'sd2116,   16'sd0,
    16'sd0,     16'sd2943,   16'sd8002,   16'sd2943,   16'sd0
  };

  localparam coef_t KXY [WIN_SIZE] = '{
    16'sd2943,  16'sd8002,   16'sd0, -16'sd8002,  -16'sd2943,
    16'sd8002,  16'sd21751,  16'sd0, -16'sd21751, -16'sd8002,
    16'sd0,     16'sd0,      16'sd0, 16'sd0,      16'sd0,
    -16'sd8002, -16'sd21751, 16'sd0, 16'sd21751,  16'sd8002,
    -16'sd2943, -16'sd8002,  16'sd0, 16'sd8002,   16'sd2943
  };

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_FINISH
  } wwh_state_e;

  typedef struct packed {
    logic                capture;   // multiply the incoming sample
    logic [CNT_BITS-1:0] coef_idx;  // window position of that sample
    logic                coef_zero; // position lies beyond the window
    logic                accum;     // add the product registers
    logic                finish;    // load the result, restart the sums
    logic                err;       // the window had the wrong length
  } wwh_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/weighted_window_hessian.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_window_hessian: Gaussian-weighted Hessian of a 5x5 sample window
// Streams in a 5x5 window of signed fixed-point samples and returns the
// negated, saturated Hessian entries at the window centre.
// ----------------------------------------------------------------------------
// The block takes the 25 samples of a window in row-major order, one word per
// cycle while s_axis_tready_o is high, with tlast on the final sample. Since
// the weighted 3x3 finite differences are linear in the samples, every sample
// is multiplied as it arrives by three folded coefficients (one each for xx,
// yy and xy) and added into three accumulators; no window store is kept.
// Once the last sample has passed the product registers and been added into
// the accumulators, the result is loaded into the output register; from the
// last sample until that load the input is not ready. Further samples are
// taken while a result waits on the output; a following window's result waits
// in turn until the previous one is taken. Outputs are negated, rounded to
// nearest (ties upward before negation) and saturated to plus or minus 2^25
// (xx, yy) and 2^23 (xy, already divided by four). A window that closes at
// other than 25 samples gives a word with the error flag set and zero data.
// ----------------------------------------------------------------------------
module weighted_window_hessian #(
  parameter int unsigned SAMPLE_BITS = wwh_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned M_TDATA_BITS =
    ((2 * wwh_pkg::DXX_BITS + wwh_pkg::DXY_BITS + 7) / 8) * 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Slave side: tdata holds sample_value in the low bits, upper bits unused.
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata_i,
  input  wire logic                    s_axis_tlast_i,   // window_last
  // Master side: tdata holds neg_dxx, neg_dxy, neg_dyy from bit 0 up, then zero.
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output logic [M_TDATA_BITS-1:0]      m_axis_tdata_o,
  output logic                         m_axis_tuser_o    // window_error
);
  import wwh_pkg::*;

  wwh_cmd_t            cmd;
  logic [DXX_BITS-1:0] neg_dxx, neg_dyy;
  logic [DXY_BITS-1:0] neg_dxy;

  wwh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  wwh_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       ($signed(s_axis_tdata_i[SAMPLE_BITS-1:0])),
    .cmd_i          (cmd),
    .neg_dxx_o      (neg_dxx),
    .neg_dxy_o      (neg_dxy),
    .neg_dyy_o      (neg_dyy),
    .window_error_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = M_TDATA_BITS'({neg_dyy, neg_dxy, neg_dxx});

endmodule
`default_nettype wire

// File: hw/rtl/wwh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwh_ctrl: window sequencer
// Counts samples, checks the window length and steps the datapath through
// multiply, accumulate and result load; owns the output valid flag.
// ----------------------------------------------------------------------------
module wwh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tlast_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output wwh_pkg::wwh_cmd_t      cmd_o
);
  import wwh_pkg::*;

  wwh_state_e          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                err_q, err_d;
  logic                pend_q, pend_d;
  logic                out_vld_q, out_vld_d;
  logic                take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACCUM;
      cnt_q     <= '0;
      err_q     <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    err_d           = err_q;
    s_tready_o      = 1'b0;
    take            = 1'b0;
    cmd_o.capture   = 1'b0;
    cmd_o.coef_idx  = cnt_q;
    cmd_o.coef_zero = (cnt_q >= CNT_FULL);
    cmd_o.accum     = pend_q;
    cmd_o.finish    = 1'b0;
    cmd_o.err       = err_q;
    unique case (state_q)
      ST_ACCUM: begin
        s_tready_o    = 1'b1;
        take          = s_tvalid_i;
        cmd_o.capture = take;
        if (take) begin
          cnt_d = cnt_inc;
          if (s_tlast_i) begin
            err_d   = (cnt_inc != CNT_FULL);
            cnt_d   = '0;
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || m_tready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  assign pend_d     = take;
  assign out_vld_d  = cmd_o.finish | (out_vld_q & ~m_tready_i);
  assign m_tvalid_o = out_vld_q;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_vld_q || m_tready_i))
    else $error("result loaded over a pending result");

  // The last product is added before the result is formed.
  a_accum_before_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.accum && cmd_o.finish))
    else $error("accumulate and finish in the same cycle");

  // The count restarts once a window has closed.
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACCUM) |-> (cnt_q == '0))
    else $error("sample count not cleared after window close");

  // Output valid only rises after a result load.
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(cmd_o.finish))
    else $error("output valid without a result load");

endmodule
`default_nettype wire

// File: hw/rtl/wwh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwh_datapath: multiply-accumulate datapath
// Three coefficient multipliers feed three accumulators; the result stage
// scales, negates and saturates the sums into the output register (zeros on error).
// ----------------------------------------------------------------------------
module wwh_datapath #(
  parameter int unsigned SAMPLE_BITS = wwh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire wwh_pkg::wwh_cmd_t             cmd_i,
  output logic [wwh_pkg::DXX_BITS-1:0]       neg_dxx_o,
  output logic [wwh_pkg::DXY_BITS-1:0]       neg_dxy_o,
  output logic [wwh_pkg::DXX_BITS-1:0]       neg_dyy_o,
  output logic                               window_error_o
);
  import wwh_pkg::*;

  localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS  = SAMPLE_BITS + ACC_EXTRA;
  localparam int unsigned SH_BITS   = ACC_BITS - WEIGHT_BITS + 1;
  localparam int unsigned CMP_BITS  = (SH_BITS > DXX_BITS + 1) ? SH_BITS : DXX_BITS + 1;

  // Starting the sums at half an output step makes the final shift round.
  localparam logic signed [ACC_BITS-1:0] RND_XX = ACC_BITS'(1 << (WEIGHT_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] RND_XY = ACC_BITS'(1 << (WEIGHT_BITS + 1));
  localparam logic signed [CMP_BITS-1:0] XX_LIM = CMP_BITS'(DXX_LIM);
  localparam logic signed [CMP_BITS-1:0] XY_LIM = CMP_BITS'(DXY_LIM);

  coef_t                       cxx, cyy, cxy;
  logic signed [PROD_BITS-1:0] pxx_q, pyy_q, pxy_q;
  logic signed [ACC_BITS-1:0]  axx_q, ayy_q, axy_q, axx_d, ayy_d, axy_d;
  logic signed [CMP_BITS-1:0]  nxx, nyy, nxy, sxx, syy, sxy;
  logic [DXX_BITS-1:0]         oxx_q, oyy_q;
  logic [DXY_BITS-1:0]         oxy_q;
  logic                        oerr_q;

  always_comb begin
    if (cmd_i.coef_zero) begin
      cxx = '0;
      cyy = '0;
      cxy = '0;
    end else begin
      cxx = KXX[cmd_i.coef_idx];
      cyy = KYY[cmd_i.coef_idx];
      cxy = KXY[cmd_i.coef_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pxx_q <= sample_i * cxx;
      pyy_q <= sample_i * cyy;
      pxy_q <= sample_i * cxy;
    end
  end

  always_comb begin
    axx_d = axx_q;
    ayy_d = ayy_q;
    axy_d = axy_q;
    if (cmd_i.finish) begin
      axx_d = RND_XX;
      ayy_d = RND_XX;
      axy_d = RND_XY;
    end else if (cmd_i.accum) begin
      axx_d = axx_q + ACC_BITS'(pxx_q);
      ayy_d = ayy_q + ACC_BITS'(pyy_q);
      axy_d = axy_q + ACC_BITS'(pxy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axx_q <= RND_XX;
      ayy_q <= RND_XX;
      axy_q <= RND_XY;
    end else begin
      axx_q <= axx_d;
      ayy_q <= ayy_d;
      axy_q <= axy_d;
    end
  end

  assign nxx = -(CMP_BITS'(axx_q >>> WEIGHT_BITS));
  assign nyy = -(CMP_BITS'(ayy_q >>> WEIGHT_BITS));
  assign nxy = -(CMP_BITS'(axy_q >>> (WEIGHT_BITS + 2)));

  always_comb begin
    sxx = nxx;
    if (nxx > XX_LIM) begin
      sxx = XX_LIM;
    end else if (nxx < -XX_LIM) begin
      sxx = -XX_LIM;
    end
    syy = nyy;
    if (nyy > XX_LIM) begin
      syy = XX_LIM;
    end else if (nyy < -XX_LIM) begin
      syy = -XX_LIM;
    end
    sxy = nxy;
    if (nxy > XY_LIM) begin
      sxy = XY_LIM;
    end else if (nxy < -XY_LIM) begin
      sxy = -XY_LIM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      oerr_q <= cmd_i.err;
      if (cmd_i.err) begin
        oxx_q <= '0;
        oyy_q <= '0;
        oxy_q <= '0;
      end else begin
        oxx_q <= sxx[DXX_BITS-1:0];
        oyy_q <= syy[DXX_BITS-1:0];
        oxy_q <= sxy[DXY_BITS-1:0];
      end
    end
  end

  assign neg_dxx_o      = oxx_q;
  assign neg_dyy_o      = oyy_q;
  assign neg_dxy_o      = oxy_q;
  assign window_error_o = oerr_q;

endmodule
`default_nettype wire
